// ----- hw/rtl/vpp_pwm_trim_controller_unit_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef VPP_PWM_TRIM_CONTROLLER_UNIT_ASSERT_SVH
`define VPP_PWM_TRIM_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VPPTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpptc: property failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VPPTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpptc: property failed");

`endif

// ----- hw/rtl/vpptc_pkg.sv -----
`default_nettype none

package vpptc_pkg;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  localparam logic [2:0] REG_GAIN_UNLOADED   = 3'd0;
  localparam logic [2:0] REG_OFFSET_UNLOADED = 3'd1;
  localparam logic [2:0] REG_GAIN_LOADED     = 3'd2;
  localparam logic [2:0] REG_OFFSET_LOADED   = 3'd3;
  localparam logic [2:0] REG_LOOP_MODE       = 3'd4;
  localparam logic [2:0] REG_ADC_PER_VOLT    = 3'd5;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ADC  = 2'd1;

  localparam logic [15:0] RST_GAIN_UNLOADED   = 16'd666;
  localparam logic [15:0] RST_OFFSET_UNLOADED = 16'd4096;
  localparam logic [15:0] RST_GAIN_LOADED     = 16'd1434;
  localparam logic [15:0] RST_OFFSET_LOADED   = 16'd8960;
  localparam logic [1:0]  RST_LOOP_MODE       = 2'd2;
  localparam logic [15:0] RST_ADC_PER_VOLT    = 16'd16692;

  // Voltages in Q5.8 volts.
  localparam logic [12:0] TARGET_LOW   = 13'd1280;
  localparam logic [12:0] TARGET_MIN   = 13'd2176;
  localparam logic [12:0] TARGET_MAX   = 13'd3584;
  localparam logic [12:0] TOLERANCE    = 13'd51;

  localparam logic [6:0] DUTY_MAX      = 7'd100;
  localparam logic [6:0] TRIM_DUTY_MIN = 7'd5;
  localparam logic [6:0] TRIM_DUTY_MAX = 7'd70;
  localparam logic [9:0] ADC_MAX       = 10'd1023;

  localparam logic [4:0] MAX_TRIES     = 5'd20;
  localparam logic [1:0] MAX_REVERSALS = 2'd2;

  // floor(x * RECIP_TEN / 2**19) equals floor(x / 10) for every 16-bit x.
  localparam logic [15:0] RECIP_TEN = 16'd52429;

  typedef enum logic [2:0] {
    ST_AWAIT = 3'd0,
    ST_DONE  = 3'd1,
    ST_RANGE = 3'd2,
    ST_TOL   = 3'd3,
    ST_LOW   = 3'd4
  } status_t;

  typedef struct packed {
    logic        command;
    logic [12:0] target_voltage;
    logic [12:0] measured_voltage;
  } req_t;

  typedef struct packed {
    logic [6:0] duty_unloaded;
    logic [6:0] duty_loaded;
    logic [9:0] adc_setpoint;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic [15:0] gain_unloaded;
    logic [15:0] offset_unloaded;
    logic [15:0] gain_loaded;
    logic [15:0] offset_loaded;
    logic [1:0]  loop_mode;
    logic [15:0] adc_counts_per_volt;
  } cfg_t;

  typedef struct packed {
    req_t               item;
    logic [28:0]        prod_unl;
    logic [28:0]        prod_ld;
    logic [28:0]        prod_adc;
    logic signed [13:0] err;
    logic signed [30:0] prod_err;
  } prod_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vpptc_mul.sv -----
`default_nettype none

module vpptc_mul (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire vpptc_pkg::req_t     item,
  input  wire logic [12:0]         target_ref,
  input  wire vpptc_pkg::cfg_t     cfg,
  output vpptc_pkg::prod_t         prod
);
  import vpptc_pkg::*;

  logic signed [13:0] err;
  prod_t              prod_next;

  always_comb begin
    err = $signed({1'b0, target_ref}) - $signed({1'b0, item.measured_voltage});
    prod_next.item     = item;
    prod_next.prod_unl = 29'(item.target_voltage) * 29'(cfg.gain_unloaded);
    prod_next.prod_ld  = 29'(item.target_voltage) * 29'(cfg.gain_loaded);
    prod_next.prod_adc = 29'(item.target_voltage) * 29'(cfg.adc_counts_per_volt);
    prod_next.err      = err;
    prod_next.prod_err = 31'(err) * $signed({15'b0, cfg.gain_unloaded});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vpptc_step.sv -----
`default_nettype none

module vpptc_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                commit,
  input  wire vpptc_pkg::prod_t    d,
  input  wire vpptc_pkg::cfg_t     cfg,
  output vpptc_pkg::rsp_t          rsp,
  output logic [12:0]              target_next
);
  import vpptc_pkg::*;

  logic [6:0]        duty_now, duty_now_next;
  logic [6:0]        duty_loaded_held, duty_loaded_held_next;
  logic [12:0]       target_held, target_held_next;
  logic [4:0]        tries, tries_next;
  logic [1:0]        reversals_left, reversals_left_next;
  logic signed [7:0] previous_step, previous_step_next;
  logic              trimming_active, trimming_active_next;
  logic              first_trim, first_trim_next;

  logic [12:0]        t, m, diff;
  logic               is_low, in_tol, out_range;
  logic signed [30:0] sum_du, sum_dl;
  logic [29:0]        sum_adc;
  logic [6:0]         du_c, dl_c;
  logic [9:0]         adc_c;
  logic [13:0]        mag;
  logic               trim_tol;
  logic signed [31:0] sum_raw;
  logic signed [15:0] raw, neg_raw;
  logic [15:0]        div_in;
  logic [31:0]        div_prod;
  logic [12:0]        q10;
  logic signed [13:0] applied;
  logic               app_zero, app_pos, prev_pos, rev;
  logic [1:0]         rev_left_upd;
  logic signed [7:0]  prev_sat;
  logic signed [14:0] pwm;
  logic [6:0]         pwm_c;
  logic [4:0]         tries_inc;
  logic               trim_end;

  function automatic logic [6:0] clamp_duty(input logic signed [14:0] v);
    logic [6:0] r;
    if (v < 0) begin
      r = 7'd0;
    end else if (v > 15'(DUTY_MAX)) begin
      r = DUTY_MAX;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  always_comb begin
    t = d.item.target_voltage;
    m = d.item.measured_voltage;
    diff = (m >= t) ? (m - t) : (t - m);
    is_low = t < TARGET_LOW;
    in_tol = diff <= TOLERANCE;
    out_range = (t > TARGET_MAX) || (t < TARGET_MIN);

    sum_du = $signed({2'b0, d.prod_unl}) - $signed({7'b0, cfg.offset_unloaded, 8'b0})
             + 31'sd32768;
    sum_dl = $signed({2'b0, d.prod_ld}) - $signed({7'b0, cfg.offset_loaded, 8'b0});
    du_c = clamp_duty(sum_du[30:16]);
    dl_c = clamp_duty(sum_dl[30:16]);

    sum_adc = {1'b0, d.prod_adc} + 30'd32768;
    adc_c = (sum_adc[29:16] > 14'(ADC_MAX)) ? ADC_MAX : sum_adc[25:16];

    mag = (d.err < 0) ? 14'(-d.err) : 14'(d.err);
    trim_tol = mag <= 14'(TOLERANCE);

    sum_raw = 32'(d.prod_err) + 32'sd32768;
    raw = sum_raw[31:16];
    neg_raw = -raw;
    div_in = (raw >= 0) ? ({raw[12:0], 3'b0} + 16'd5) : {neg_raw[14:0], 1'b0};
    div_prod = div_in * RECIP_TEN;
    q10 = div_prod[31:19];
    if (raw >= 0) begin
      applied = $signed({1'b0, q10});
    end else if (raw < -16'sd5) begin
      applied = -$signed({1'b0, q10});
    end else begin
      applied = -14'sd1;
    end

    app_zero = applied == 0;
    app_pos = applied > 0;
    prev_pos = previous_step > 0;
    rev = app_zero || (previous_step == 0) || (app_pos != prev_pos);
    rev_left_upd = (!first_trim && rev && (reversals_left != 2'd0))
                   ? reversals_left - 2'd1 : reversals_left;
    if (applied > 14'sd127) begin
      prev_sat = 8'sd127;
    end else if (applied < -14'sd128) begin
      prev_sat = -8'sd128;
    end else begin
      prev_sat = applied[7:0];
    end

    pwm = $signed({8'b0, duty_now}) + 15'(applied);
    if (pwm > $signed({8'b0, TRIM_DUTY_MAX})) begin
      pwm_c = TRIM_DUTY_MAX;
    end else if (pwm < $signed({8'b0, TRIM_DUTY_MIN})) begin
      pwm_c = TRIM_DUTY_MIN;
    end else begin
      pwm_c = pwm[6:0];
    end
    tries_inc = tries + 5'd1;
    trim_end = app_zero || (tries_inc >= MAX_TRIES) || (pwm_c <= TRIM_DUTY_MIN) ||
               (pwm_c >= TRIM_DUTY_MAX) || (rev_left_upd == 2'd0);
  end

  always_comb begin
    duty_now_next = duty_now;
    duty_loaded_held_next = duty_loaded_held;
    target_held_next = target_held;
    tries_next = tries;
    reversals_left_next = reversals_left;
    previous_step_next = previous_step;
    trimming_active_next = trimming_active;
    first_trim_next = first_trim;
    rsp = '0;

    if (d.item.command == CMD_START) begin
      trimming_active_next = 1'b0;
      if (is_low) begin
        rsp.status = ST_LOW;
      end else if (in_tol) begin
        rsp.status = ST_TOL;
      end else if (out_range) begin
        rsp.status = ST_RANGE;
      end else begin
        duty_now_next = du_c;
        duty_loaded_held_next = dl_c;
        target_held_next = t;
        rsp.duty_unloaded = du_c;
        rsp.duty_loaded = dl_c;
        rsp.status = ST_DONE;
        case (cfg.loop_mode)
          MODE_NONE: begin
          end
          MODE_ADC: begin
            rsp.adc_setpoint = adc_c;
          end
          default: begin
            tries_next = 5'd0;
            reversals_left_next = MAX_REVERSALS;
            previous_step_next = 8'sd0;
            first_trim_next = 1'b1;
            if ((du_c > TRIM_DUTY_MIN) && (du_c < TRIM_DUTY_MAX)) begin
              trimming_active_next = 1'b1;
              rsp.status = ST_AWAIT;
            end
          end
        endcase
      end
    end else begin
      rsp.duty_unloaded = duty_now;
      rsp.duty_loaded = duty_loaded_held;
      rsp.status = ST_DONE;
      if (trimming_active) begin
        if (trim_tol) begin
          trimming_active_next = 1'b0;
        end else begin
          tries_next = tries_inc;
          reversals_left_next = rev_left_upd;
          first_trim_next = 1'b0;
          previous_step_next = prev_sat;
          duty_now_next = pwm_c;
          rsp.duty_unloaded = pwm_c;
          if (trim_end) begin
            trimming_active_next = 1'b0;
          end else begin
            rsp.status = ST_AWAIT;
          end
        end
      end
    end

    target_next = commit ? target_held_next : target_held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now <= 7'd0;
      duty_loaded_held <= 7'd0;
      target_held <= 13'd0;
      tries <= 5'd0;
      reversals_left <= MAX_REVERSALS;
      previous_step <= 8'sd0;
      trimming_active <= 1'b0;
      first_trim <= 1'b1;
    end else if (commit) begin
      duty_now <= duty_now_next;
      duty_loaded_held <= duty_loaded_held_next;
      target_held <= target_held_next;
      tries <= tries_next;
      reversals_left <= reversals_left_next;
      previous_step <= previous_step_next;
      trimming_active <= trimming_active_next;
      first_trim <= first_trim_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vpp_pwm_trim_controller_unit.sv -----
// Boost converter PWM duty controller for a programming voltage.
// The request channel (req_valid, req_stall, req) carries one start or
// measurement transaction; the response channel (rsp_valid, rsp_stall, rsp)
// returns exactly one result transaction for each request, in order.
// A transaction moves at a rising edge with valid high and stall low.
// Registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high, so every write is taken when cfg_valid is high. Write them only
// while no request is in flight.
// A request, once accepted, passes an input register, a register after the
// gain multipliers, and the response register. While the receiver does not
// stall, a new request is accepted every cycle; the throughput is one
// transaction per cycle, set by the state update after the multiplier
// register.
// When the receiver stalls, the response register holds its transaction and
// the stages behind it keep filling until both are occupied, then req_stall
// rises. Reset (rst, synchronous, active high) empties the pipeline, restores
// the register defaults and clears the trim state.
`default_nettype none

module vpp_pwm_trim_controller_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire vpptc_pkg::req_t   req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output vpptc_pkg::rsp_t        rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import vpptc_pkg::*;

  cfg_t        cfg;
  req_t        s1;
  logic        s1_valid;
  logic        s2_valid;
  prod_t       s2;
  rsp_t        step_rsp;
  logic [12:0] target_next;
  logic        rsp_load, s2_free, s2_move, s1_free, s1_move, accept;

  always_comb begin
    rsp_load = !rsp_valid || !rsp_stall;
    s2_free = !s2_valid || rsp_load;
    s2_move = s2_valid && rsp_load;
    s1_free = !s1_valid || s2_free;
    s1_move = s1_valid && s2_free;
    req_stall = !s1_free;
    accept = req_valid && s1_free;
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= req_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (rsp_load) begin
        rsp_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
    if (s2_move) begin
      rsp <= step_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_unloaded <= RST_GAIN_UNLOADED;
      cfg.offset_unloaded <= RST_OFFSET_UNLOADED;
      cfg.gain_loaded <= RST_GAIN_LOADED;
      cfg.offset_loaded <= RST_OFFSET_LOADED;
      cfg.loop_mode <= RST_LOOP_MODE;
      cfg.adc_counts_per_volt <= RST_ADC_PER_VOLT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_UNLOADED:   cfg.gain_unloaded <= cfg_data;
        REG_OFFSET_UNLOADED: cfg.offset_unloaded <= cfg_data;
        REG_GAIN_LOADED:     cfg.gain_loaded <= cfg_data;
        REG_OFFSET_LOADED:   cfg.offset_loaded <= cfg_data;
        REG_LOOP_MODE:       cfg.loop_mode <= cfg_data[1:0];
        REG_ADC_PER_VOLT:    cfg.adc_counts_per_volt <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vpptc_mul u_mul (
    .clk        (clk),
    .load       (s1_move),
    .item       (s1),
    .target_ref (target_next),
    .cfg        (cfg),
    .prod       (s2)
  );

  vpptc_step u_step (
    .clk         (clk),
    .rst         (rst),
    .commit      (s2_move),
    .d           (s2),
    .cfg         (cfg),
    .rsp         (step_rsp),
    .target_next (target_next)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/vpptc_checker.sv -----
`default_nettype none

`include "vpp_pwm_trim_controller_unit_assert.svh"

module vpptc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire vpptc_pkg::rsp_t   rsp
);
  import vpptc_pkg::*;

  logic rsp_rejected;
  logic rsp_awaiting;
  logic rsp_zero;
  logic rsp_adc_set;
  logic duty_in_window;
  logic duty_in_range;

  assign rsp_rejected = (rsp.status == ST_LOW) || (rsp.status == ST_TOL) ||
                        (rsp.status == ST_RANGE);
  assign rsp_awaiting = rsp.status == ST_AWAIT;
  assign rsp_zero = (rsp.duty_unloaded == 7'd0) && (rsp.duty_loaded == 7'd0) &&
                    (rsp.adc_setpoint == 10'd0);
  assign rsp_adc_set = rsp.adc_setpoint != 10'd0;
  assign duty_in_window = (rsp.duty_unloaded > TRIM_DUTY_MIN) &&
                          (rsp.duty_unloaded < TRIM_DUTY_MAX);
  assign duty_in_range = (rsp.duty_unloaded <= DUTY_MAX) && (rsp.duty_loaded <= DUTY_MAX);

  // A stalled response transaction is held unchanged.
  `VPPTC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  `VPPTC_ASSERT_IMPLY(a_reject_zero, clk, rst, rsp_valid && rsp_rejected, rsp_zero)

  `VPPTC_ASSERT_IMPLY(a_adc_only_done, clk, rst, rsp_valid && rsp_adc_set, rsp.status == ST_DONE)

  `VPPTC_ASSERT_IMPLY(a_trim_window, clk, rst, rsp_valid && rsp_awaiting, duty_in_window)

  `VPPTC_ASSERT_IMPLY(a_duty_limit, clk, rst, rsp_valid, duty_in_range)

endmodule

bind vpp_pwm_trim_controller_unit vpptc_checker u_checker (.*);

`default_nettype wire
